// ===== sv/alias_table_builder_assert.svh =====
// ============================================================================
// alias_table_builder_assert.svh
// Assertion macros used by the alias table builder back end (abt_back).
// ============================================================================
`ifndef ALIAS_TABLE_BUILDER_ASSERT_SVH
`define ALIAS_TABLE_BUILDER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define ABT_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("alias table builder assertion failed");
// Next-cycle implication, disabled during reset
`define ABT_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("alias table builder assertion failed");
`else
`define ABT_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define ABT_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== sv/abt_pkg.sv =====
// ============================================================================
// abt_pkg
// Shared types and constants of the alias table builder.
// ============================================================================
package abt_pkg;

    localparam int WEIGHT_W          = 32;
    localparam int TOTAL_W           = 40;
    localparam int CFG_W             = 7;
    localparam int CFG_RESET         = 64;
    localparam int SCALE_EXTRA       = 7;
    localparam int MAX_ENTRIES_DEF   = 64;
    localparam int FRAC_BITS_DEF     = 16;

    // Build request handed from the front to the back
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [CFG_W-1:0]   cnt;
        logic               zero;
    } cmd_t;

    // Back status seen by the front
    typedef struct packed {
        logic weights_busy;
        logic cmd_take;
    } back_status_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SC_RD,
        B_SC_MUL,
        B_SC_DIV,
        B_SC_WAIT,
        B_PR_POP,
        B_PR_IDX,
        B_PR_RDL,
        B_PR_CALC,
        B_DR_RD,
        B_DR_WR,
        B_EM_RD,
        B_EM_LD
    } back_state_t;

endpackage

// ===== sv/abt_if.sv =====
// ============================================================================
// abt_if
// Channel interfaces of the alias table builder.
// ============================================================================
interface abt_item_if;
    logic                         valid;
    logic                         ready;
    logic [abt_pkg::WEIGHT_W-1:0] weight;
    logic [abt_pkg::TOTAL_W-1:0]  total;
    modport source (output valid, output weight, output total, input ready);
    modport sink   (input valid, input weight, input total, output ready);
endinterface

interface abt_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [abt_pkg::CFG_W-1:0] entry_count;
    modport source (output valid, output entry_count, input ready);
    modport sink   (input valid, input entry_count, output ready);
endinterface

interface abt_result_if #(
    parameter int IDX_W  = 6,
    parameter int PROB_W = 17
);
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  entry_index;
    logic [PROB_W-1:0] probability;
    logic [IDX_W-1:0]  alias_index;
    logic              zero_total;
    logic              last;
    modport source (output valid, output entry_index, output probability,
                    output alias_index, output zero_total, output last, input ready);
    modport sink   (input valid, input entry_index, input probability,
                    input alias_index, input zero_total, input last, output ready);
endinterface

// ===== sv/abt_ram.sv =====
// ============================================================================
// abt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module abt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/abt_divider.sv =====
// ============================================================================
// abt_divider
// Restoring divider, one quotient bit per cycle, saturating quotient.
// ============================================================================
module abt_divider #(
    parameter int NUM_W   = 55,
    parameter int SCALE_W = 23
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NUM_W-1:0]            num,
    input  logic [abt_pkg::TOTAL_W-1:0] den,
    output logic                        done,
    output logic [SCALE_W-1:0]          quot
);

    localparam int DW     = abt_pkg::TOTAL_W + SCALE_W;
    localparam int STEP_W = $clog2(SCALE_W + 1);

    logic [DW-1:0]      rem_reg, rem_next;
    logic [DW-1:0]      dsh_reg, dsh_next;
    logic [SCALE_W-1:0] q_reg, q_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               sat;

    // Quotient overflows its width when num >= den * 2^SCALE_W
    assign sat = abt_pkg::TOTAL_W'(num >> SCALE_W) >= den;

    // Next values: load on start, then one trial subtract per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            if (sat)
            begin
                q_next    = '1;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = DW'(num);
                dsh_next  = DW'(den) << (SCALE_W - 1);
                q_next    = '0;
                step_next = STEP_W'(SCALE_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[SCALE_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[SCALE_W-2:0], 1'b0};
            end
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        step_reg <= step_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== sv/abt_front.sv =====
// ============================================================================
// abt_front
// Loads weights, holds entry_count and queues one build request.
// ============================================================================
module abt_front #(
    parameter int MAX_ENTRIES = abt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    abt_item_if.sink                            items,
    abt_cfg_if.sink                             cfg,
    input  abt_pkg::back_status_t               status,
    output logic                                cmd_valid,
    output abt_pkg::cmd_t                       cmd,
    output logic                                w_wr_en,
    output logic [$clog2(MAX_ENTRIES)-1:0]      w_wr_addr,
    output logic [abt_pkg::WEIGHT_W-1:0]        w_wr_data
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CW    = abt_pkg::CFG_W;

    logic [CW-1:0]  entry_count_reg;
    logic [CW-1:0]  load_count_reg;
    logic           cmd_valid_reg;
    abt_pkg::cmd_t  cmd_reg;
    logic [CW-1:0]  cnt_act;
    logic           accept;
    logic           set_done;

    // Clamp entry_count into 1..MAX_ENTRIES
    always_comb
    begin
        if (entry_count_reg == '0)
        begin
            cnt_act = CW'(1);
        end
        else if (entry_count_reg > CW'(MAX_ENTRIES))
        begin
            cnt_act = CW'(MAX_ENTRIES);
        end
        else
        begin
            cnt_act = entry_count_reg;
        end
    end

    // Hold requests while a build is queued or the back reads the weights
    assign items.ready = !cmd_valid_reg && !status.weights_busy;
    assign cfg.ready   = 1'b1;
    assign accept      = items.valid && items.ready;
    assign set_done    = CW'(load_count_reg + 1'b1) >= cnt_act;

    // Store each weight at its load position
    assign w_wr_en   = accept;
    assign w_wr_addr = load_count_reg[IDX_W-1:0];
    assign w_wr_data = items.weight;

    // Load counter, register and build request slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= CW'(abt_pkg::CFG_RESET);
            load_count_reg  <= '0;
            cmd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                entry_count_reg <= cfg.entry_count;
                load_count_reg  <= '0;
            end
            else if (accept)
            begin
                load_count_reg <= set_done ? '0 : CW'(load_count_reg + 1'b1);
            end
            if (accept && set_done)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (status.cmd_take)
            begin
                cmd_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload
    always_ff @(posedge clk)
    begin
        if (accept && set_done)
        begin
            cmd_reg.total <= items.total;
            cmd_reg.cnt   <= cnt_act;
            cmd_reg.zero  <= (items.total == '0);
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== sv/abt_back.sv =====
// ============================================================================
// abt_back
// Scales weights, pairs the small and large worklists, emits the table.
// ============================================================================
`include "alias_table_builder_assert.svh"

module abt_back #(
    parameter int MAX_ENTRIES = abt_pkg::MAX_ENTRIES_DEF,
    parameter int FRAC_BITS   = abt_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  abt_pkg::cmd_t                  cmd,
    output abt_pkg::back_status_t          status,
    output logic [$clog2(MAX_ENTRIES)-1:0] w_rd_addr,
    input  logic [abt_pkg::WEIGHT_W-1:0]   w_rd_data,
    abt_result_if.source                   results
);

    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CW      = abt_pkg::CFG_W;
    localparam int PROB_W  = FRAC_BITS + 1;
    localparam int SCALE_W = FRAC_BITS + abt_pkg::SCALE_EXTRA;
    localparam int NUM_W   = abt_pkg::WEIGHT_W + CW + FRAC_BITS;
    localparam int PROD_W  = abt_pkg::WEIGHT_W + CW;
    localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
    localparam logic [SCALE_W:0]   ONE_S     = (SCALE_W + 1)'(1) << FRAC_BITS;
    localparam logic [PROB_W-1:0]  ONE_P     = PROB_W'(1) << FRAC_BITS;
    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(MAX_ENTRIES - 1);

    abt_pkg::back_state_t state_reg, state_next;

    logic [CW-1:0]                i_reg, i_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         zero_reg, zero_next;
    logic [abt_pkg::TOTAL_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]             sh_reg, sh_next, st_reg, st_next;
    logic [IDX_W-1:0]             lh_reg, lh_next, lt_reg, lt_next;
    logic [CW-1:0]                sc_reg, sc_next, lc_reg, lc_next;
    logic [IDX_W-1:0]             sm_reg, sm_next, lg_reg, lg_next;
    logic [SCALE_W-1:0]           ssm_reg, ssm_next;
    logic [NUM_W-1:0]             num_reg, num_next;
    logic                         drain_large_reg, drain_large_next;
    logic [MAX_ENTRIES-1:0]       alias_vld_reg, alias_vld_next;

    logic                         ov_reg, ov_next;
    logic [IDX_W-1:0]             o_idx_reg, o_idx_next;
    logic [PROB_W-1:0]            o_prob_reg, o_prob_next;
    logic [IDX_W-1:0]             o_alias_reg, o_alias_next;
    logic                         o_zero_reg, o_zero_next;
    logic                         o_last_reg, o_last_next;

    logic                         div_start, div_done;
    logic [SCALE_W-1:0]           div_q;

    logic                         s_wr_en;
    logic [IDX_W-1:0]             s_wr_addr, s_rd_addr;
    logic [SCALE_W-1:0]           s_wr_data, s_rd_data;
    logic                         sm_wr_en, lg_wr_en;
    logic [IDX_W-1:0]             sm_rd_data, lg_rd_data;
    logic [IDX_W-1:0]             push_idx;
    logic                         p_wr_en;
    logic [IDX_W-1:0]             p_wr_addr;
    logic [PROB_W-1:0]            p_wr_data, p_rd_data;
    logic                         a_wr_en;
    logic [IDX_W-1:0]             a_rd_data;

    logic [IDX_W-1:0]             i_idx;
    logic                         i_last;
    logic                         out_load;
    logic [SCALE_W:0]             red_sum;
    logic [SCALE_W-1:0]           red_sat;
    logic [PROD_W-1:0]            prod;

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_LAST) ? '0 : IDX_W'(p + 1'b1);
    endfunction

    assign i_idx    = i_reg[IDX_W-1:0];
    assign i_last   = CW'(i_reg + 1'b1) == cnt_reg;
    assign out_load = (state_reg == abt_pkg::B_EM_LD) && (!ov_reg || results.ready);
    assign prod     = PROD_W'(w_rd_data) * PROD_W'(cnt_reg);

    // Reduce the large entry by one minus the small share
    assign red_sum = (SCALE_W + 1)'(s_rd_data) + (SCALE_W + 1)'(ssm_reg) - ONE_S;
    assign red_sat = (red_sum > (SCALE_W + 1)'(SCALE_MAX)) ? SCALE_MAX
                                                          : red_sum[SCALE_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            abt_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = cmd.zero ? abt_pkg::B_EM_RD : abt_pkg::B_SC_RD;
                end
            end
            abt_pkg::B_SC_RD:   state_next = abt_pkg::B_SC_MUL;
            abt_pkg::B_SC_MUL:  state_next = abt_pkg::B_SC_DIV;
            abt_pkg::B_SC_DIV:  state_next = abt_pkg::B_SC_WAIT;
            abt_pkg::B_SC_WAIT:
            begin
                if (div_done)
                begin
                    state_next = i_last ? abt_pkg::B_PR_POP : abt_pkg::B_SC_RD;
                end
            end
            abt_pkg::B_PR_POP:
            begin
                state_next = (sc_reg == '0 || lc_reg == '0) ? abt_pkg::B_DR_RD
                                                            : abt_pkg::B_PR_IDX;
            end
            abt_pkg::B_PR_IDX:  state_next = abt_pkg::B_PR_RDL;
            abt_pkg::B_PR_RDL:  state_next = abt_pkg::B_PR_CALC;
            abt_pkg::B_PR_CALC: state_next = abt_pkg::B_PR_POP;
            abt_pkg::B_DR_RD:
            begin
                if (drain_large_reg)
                begin
                    state_next = (lc_reg == '0) ? abt_pkg::B_DR_RD : abt_pkg::B_DR_WR;
                end
                else
                begin
                    state_next = (sc_reg == '0) ? abt_pkg::B_EM_RD : abt_pkg::B_DR_WR;
                end
            end
            abt_pkg::B_DR_WR:   state_next = abt_pkg::B_DR_RD;
            abt_pkg::B_EM_RD:   state_next = abt_pkg::B_EM_LD;
            abt_pkg::B_EM_LD:
            begin
                if (out_load)
                begin
                    state_next = i_last ? abt_pkg::B_IDLE : abt_pkg::B_EM_RD;
                end
            end
            default:            state_next = abt_pkg::B_IDLE;
        endcase
    end

    // Datapath, worklist and memory controls per state
    always_comb
    begin
        i_next           = i_reg;
        cnt_next         = cnt_reg;
        zero_next        = zero_reg;
        total_next       = total_reg;
        sh_next          = sh_reg;
        st_next          = st_reg;
        lh_next          = lh_reg;
        lt_next          = lt_reg;
        sc_next          = sc_reg;
        lc_next          = lc_reg;
        sm_next          = sm_reg;
        lg_next          = lg_reg;
        ssm_next         = ssm_reg;
        num_next         = num_reg;
        drain_large_next = drain_large_reg;
        alias_vld_next   = alias_vld_reg;
        ov_next          = ov_reg && !results.ready;
        o_idx_next       = o_idx_reg;
        o_prob_next      = o_prob_reg;
        o_alias_next     = o_alias_reg;
        o_zero_next      = o_zero_reg;
        o_last_next      = o_last_reg;
        status.cmd_take     = 1'b0;
        status.weights_busy = 1'b0;
        div_start = 1'b0;
        s_wr_en   = 1'b0;
        s_wr_addr = i_idx;
        s_wr_data = div_q;
        s_rd_addr = lg_reg;
        sm_wr_en  = 1'b0;
        lg_wr_en  = 1'b0;
        push_idx  = i_idx;
        p_wr_en   = 1'b0;
        p_wr_addr = sm_reg;
        p_wr_data = ssm_reg[PROB_W-1:0];
        a_wr_en   = 1'b0;
        case (state_reg)
            abt_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    status.cmd_take  = 1'b1;
                    cnt_next         = cmd.cnt;
                    zero_next        = cmd.zero;
                    total_next       = cmd.total;
                    i_next           = '0;
                    sh_next          = '0;
                    st_next          = '0;
                    lh_next          = '0;
                    lt_next          = '0;
                    sc_next          = '0;
                    lc_next          = '0;
                    drain_large_next = 1'b1;
                end
            end
            abt_pkg::B_SC_RD:
            begin
                status.weights_busy = 1'b1;
            end
            abt_pkg::B_SC_MUL:
            begin
                status.weights_busy = 1'b1;
                num_next = NUM_W'({prod, {FRAC_BITS{1'b0}}});
            end
            abt_pkg::B_SC_DIV:
            begin
                status.weights_busy = 1'b1;
                div_start = 1'b1;
            end
            abt_pkg::B_SC_WAIT:
            begin
                status.weights_busy = 1'b1;
                if (div_done)
                begin
                    s_wr_en = 1'b1;
                    i_next  = CW'(i_reg + 1'b1);
                    // Sort into small (< 1.0) or large
                    if (div_q[SCALE_W-1:FRAC_BITS] == '0)
                    begin
                        sm_wr_en = 1'b1;
                        st_next  = ptr_inc(st_reg);
                        sc_next  = CW'(sc_reg + 1'b1);
                    end
                    else
                    begin
                        lg_wr_en = 1'b1;
                        lt_next  = ptr_inc(lt_reg);
                        lc_next  = CW'(lc_reg + 1'b1);
                    end
                end
            end
            abt_pkg::B_PR_POP:
            begin
                if (sc_reg != '0 && lc_reg != '0)
                begin
                    sh_next = ptr_inc(sh_reg);
                    lh_next = ptr_inc(lh_reg);
                    sc_next = CW'(sc_reg - 1'b1);
                    lc_next = CW'(lc_reg - 1'b1);
                end
            end
            abt_pkg::B_PR_IDX:
            begin
                sm_next   = sm_rd_data;
                lg_next   = lg_rd_data;
                s_rd_addr = sm_rd_data;
            end
            abt_pkg::B_PR_RDL:
            begin
                ssm_next = s_rd_data;
            end
            abt_pkg::B_PR_CALC:
            begin
                p_wr_en   = 1'b1;
                a_wr_en   = 1'b1;
                alias_vld_next[sm_reg] = 1'b1;
                s_wr_en   = 1'b1;
                s_wr_addr = lg_reg;
                s_wr_data = red_sat;
                push_idx  = lg_reg;
                if (red_sat[SCALE_W-1:FRAC_BITS] == '0)
                begin
                    sm_wr_en = 1'b1;
                    st_next  = ptr_inc(st_reg);
                    sc_next  = CW'(sc_reg + 1'b1);
                end
                else
                begin
                    lg_wr_en = 1'b1;
                    lt_next  = ptr_inc(lt_reg);
                    lc_next  = CW'(lc_reg + 1'b1);
                end
            end
            abt_pkg::B_DR_RD:
            begin
                if (drain_large_reg)
                begin
                    if (lc_reg == '0)
                    begin
                        drain_large_next = 1'b0;
                    end
                    else
                    begin
                        lh_next = ptr_inc(lh_reg);
                        lc_next = CW'(lc_reg - 1'b1);
                    end
                end
                else if (sc_reg != '0)
                begin
                    sh_next = ptr_inc(sh_reg);
                    sc_next = CW'(sc_reg - 1'b1);
                end
                else
                begin
                    i_next = '0;
                end
            end
            abt_pkg::B_DR_WR:
            begin
                // Leftover entries keep probability 1.0
                p_wr_en   = 1'b1;
                p_wr_addr = drain_large_reg ? lg_rd_data : sm_rd_data;
                p_wr_data = ONE_P;
            end
            abt_pkg::B_EM_RD:
            begin
            end
            abt_pkg::B_EM_LD:
            begin
                if (out_load)
                begin
                    ov_next      = 1'b1;
                    o_idx_next   = i_idx;
                    o_prob_next  = zero_reg ? ONE_P : p_rd_data;
                    o_alias_next = alias_vld_reg[i_idx] ? a_rd_data : '0;
                    o_zero_next  = zero_reg;
                    o_last_next  = i_last;
                    i_next       = CW'(i_reg + 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= abt_pkg::B_IDLE;
            i_reg           <= '0;
            cnt_reg         <= '0;
            zero_reg        <= 1'b0;
            sh_reg          <= '0;
            st_reg          <= '0;
            lh_reg          <= '0;
            lt_reg          <= '0;
            sc_reg          <= '0;
            lc_reg          <= '0;
            drain_large_reg <= 1'b0;
            alias_vld_reg   <= '0;
            ov_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            i_reg           <= i_next;
            cnt_reg         <= cnt_next;
            zero_reg        <= zero_next;
            sh_reg          <= sh_next;
            st_reg          <= st_next;
            lh_reg          <= lh_next;
            lt_reg          <= lt_next;
            sc_reg          <= sc_next;
            lc_reg          <= lc_next;
            drain_large_reg <= drain_large_next;
            alias_vld_reg   <= alias_vld_next;
            ov_reg          <= ov_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        total_reg   <= total_next;
        sm_reg      <= sm_next;
        lg_reg      <= lg_next;
        ssm_reg     <= ssm_next;
        num_reg     <= num_next;
        o_idx_reg   <= o_idx_next;
        o_prob_reg  <= o_prob_next;
        o_alias_reg <= o_alias_next;
        o_zero_reg  <= o_zero_next;
        o_last_reg  <= o_last_next;
    end

    assign w_rd_addr = i_idx;

    abt_divider #(
        .NUM_W   (NUM_W),
        .SCALE_W (SCALE_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (total_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    abt_ram #(.WIDTH(SCALE_W), .DEPTH(MAX_ENTRIES)) u_scaled (
        .clk (clk), .wr_en (s_wr_en), .wr_addr (s_wr_addr), .wr_data (s_wr_data),
        .rd_addr (s_rd_addr), .rd_data (s_rd_data)
    );

    abt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_small (
        .clk (clk), .wr_en (sm_wr_en), .wr_addr (st_reg), .wr_data (push_idx),
        .rd_addr (sh_reg), .rd_data (sm_rd_data)
    );

    abt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_large (
        .clk (clk), .wr_en (lg_wr_en), .wr_addr (lt_reg), .wr_data (push_idx),
        .rd_addr (lh_reg), .rd_data (lg_rd_data)
    );

    abt_ram #(.WIDTH(PROB_W), .DEPTH(MAX_ENTRIES)) u_prob (
        .clk (clk), .wr_en (p_wr_en), .wr_addr (p_wr_addr), .wr_data (p_wr_data),
        .rd_addr (i_idx), .rd_data (p_rd_data)
    );

    abt_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_alias (
        .clk (clk), .wr_en (a_wr_en), .wr_addr (sm_reg), .wr_data (lg_reg),
        .rd_addr (i_idx), .rd_data (a_rd_data)
    );

    assign results.valid       = ov_reg;
    assign results.entry_index = o_idx_reg;
    assign results.probability = o_prob_reg;
    assign results.alias_index = o_alias_reg;
    assign results.zero_total  = o_zero_reg;
    assign results.last        = o_last_reg;

    `ABT_ASSERT_IMP(a_wl_bound, clk, rst_n, state_reg != abt_pkg::B_IDLE, (CW + 1)'(sc_reg) + (CW + 1)'(lc_reg) <= (CW + 1)'(cnt_reg))
    `ABT_ASSERT_IMP(a_div_wait, clk, rst_n, div_done, state_reg == abt_pkg::B_SC_WAIT)
    `ABT_ASSERT_NXT(a_last_idle, clk, rst_n, out_load && i_last, state_reg == abt_pkg::B_IDLE && o_last_reg)

endmodule

// ===== sv/alias_table_builder.sv =====
// ============================================================================
// alias_table_builder
// Builds a Vose alias table from a set of loaded weights.
// ============================================================================
// Usage: write entry_count on cfg (restarts loading). Send one weight per
// request on items; the request that completes the set also carries total.
// The front takes one weight per cycle unless a build is queued or the back
// reads the weights. After the last weight the back scales each entry with
// a serial divider, pairs the worklists, sets each unpaired entry to
// probability 1.0 and then emits entry_count results on results, last flagged.
// While a build is queued or its weights are being scaled, items.ready is
// low; loading of the next set may run during pairing and emission.
// A zero total skips scaling and emits probability 1.0 with zero_total set.
// If the receiver stalls, the result register holds and emission waits.
// Reset clears control state, entry_count returns to 64 and all aliases
// read as zero until written; no clearing pass is needed.
module alias_table_builder #(
    parameter int MAX_ENTRIES = abt_pkg::MAX_ENTRIES_DEF,
    parameter int FRAC_BITS   = abt_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    abt_item_if.sink     items,
    abt_cfg_if.sink      cfg,
    abt_result_if.source results
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    abt_pkg::back_status_t        status;
    abt_pkg::cmd_t                cmd;
    logic                         cmd_valid;
    logic                         w_wr_en;
    logic [IDX_W-1:0]             w_wr_addr, w_rd_addr;
    logic [abt_pkg::WEIGHT_W-1:0] w_wr_data, w_rd_data;

    abt_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg       (cfg),
        .status    (status),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .w_wr_en   (w_wr_en),
        .w_wr_addr (w_wr_addr),
        .w_wr_data (w_wr_data)
    );

    // Weight store shared by loader and scaler
    abt_ram #(.WIDTH(abt_pkg::WEIGHT_W), .DEPTH(MAX_ENTRIES)) u_weights (
        .clk (clk), .wr_en (w_wr_en), .wr_addr (w_wr_addr), .wr_data (w_wr_data),
        .rd_addr (w_rd_addr), .rd_data (w_rd_data)
    );

    abt_back #(.MAX_ENTRIES(MAX_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .status    (status),
        .w_rd_addr (w_rd_addr),
        .w_rd_data (w_rd_data),
        .results   (results)
    );

endmodule

// ===== tb/abt_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_table_checker
// Watches the request, config and result channels of the alias table builder.
// Keeps its own copy of the weights and tables, predicts every emitted table
// row and compares each accepted result with the oldest predicted row.
// ----------------------------------------------------------------------------
module abt_table_checker (
    input  logic       clk,
    input  logic       rst_n,
    abt_item_if        items,
    abt_cfg_if         cfg,
    abt_result_if      results,
    output int         mismatches,
    output int         rows_pending
);

    localparam int          ENTRIES  = 64;
    localparam logic [63:0] ONE_FX   = 64'd1 << 16;
    localparam logic [63:0] SCL_SAT  = (64'd1 << 23) - 64'd1;

    typedef struct {
        logic [5:0]  entry_index;
        logic [16:0] probability;
        logic [5:0]  alias_index;
        logic        zero_total;
        logic        last;
    } table_row_t;

    table_row_t     rows_q[$];
    logic [6:0]     count_reg;
    int             loaded;
    logic [31:0]    weight_mem [ENTRIES];
    logic [63:0]    scaled_mem [ENTRIES];
    logic [16:0]    prob_mem [ENTRIES];
    logic [5:0]     alias_mem [ENTRIES];

    function automatic int entries_in_use(logic [6:0] c);
        if (c == 0)
            return 1;
        if (c > ENTRIES)
            return ENTRIES;
        return int'(c);
    endfunction

    // Scale, sort into worklists and pair off (Vose construction)
    task automatic build_alias_table(int cnt, logic [39:0] sum);
        int          small_q[$];
        int          large_q[$];
        int          sm;
        int          lg;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] v;
        for (int i = 0; i < cnt; i++)
        begin
            num = ({32'd0, weight_mem[i]} * 64'(cnt)) << 16;
            q = num / {24'd0, sum};
            scaled_mem[i] = (q > SCL_SAT) ? SCL_SAT : q;
        end
        for (int i = 0; i < cnt; i++)
        begin
            if (scaled_mem[i] < ONE_FX)
                small_q.push_back(i);
            else
                large_q.push_back(i);
        end
        while (small_q.size() != 0 && large_q.size() != 0)
        begin
            sm = small_q.pop_front();
            lg = large_q.pop_front();
            prob_mem[sm] = scaled_mem[sm][16:0];
            alias_mem[sm] = lg[5:0];
            v = scaled_mem[lg] + scaled_mem[sm] - ONE_FX;
            scaled_mem[lg] = (v > SCL_SAT) ? SCL_SAT : v;
            if (scaled_mem[lg] < ONE_FX)
                small_q.push_back(lg);
            else
                large_q.push_back(lg);
        end
        while (large_q.size() != 0)
            prob_mem[large_q.pop_front()] = ONE_FX[16:0];
        while (small_q.size() != 0)
            prob_mem[small_q.pop_front()] = ONE_FX[16:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int         cnt;
        table_row_t row;
        table_row_t got;
        logic       zero;
        if (!rst_n)
        begin
            rows_q.delete();
            count_reg = 7'(abt_pkg::CFG_RESET);
            loaded = 0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                prob_mem[i] = ONE_FX[16:0];
                alias_mem[i] = '0;
            end
            mismatches <= 0;
            rows_pending <= 0;
        end
        else
        begin
            // Config write restarts loading
            if (cfg.valid && cfg.ready)
            begin
                count_reg = cfg.entry_count;
                loaded = 0;
            end
            // Load one weight; the completing request builds the table
            if (items.valid && items.ready)
            begin
                cnt = entries_in_use(count_reg);
                if (loaded < ENTRIES)
                    weight_mem[loaded] = items.weight;
                loaded++;
                if (loaded >= cnt)
                begin
                    loaded = 0;
                    zero = (items.total == '0);
                    if (zero)
                    begin
                        for (int i = 0; i < cnt; i++)
                            prob_mem[i] = ONE_FX[16:0];
                    end
                    else
                        build_alias_table(cnt, items.total);
                    for (int i = 0; i < cnt; i++)
                    begin
                        row.entry_index = i[5:0];
                        row.probability = prob_mem[i];
                        row.alias_index = alias_mem[i];
                        row.zero_total = zero;
                        row.last = (i + 1 == cnt);
                        rows_q.push_back(row);
                    end
                end
            end
            // Compare each accepted result with the oldest predicted row
            if (results.valid && results.ready)
            begin
                got.entry_index = results.entry_index;
                got.probability = results.probability;
                got.alias_index = results.alias_index;
                got.zero_total = results.zero_total;
                got.last = results.last;
                if (rows_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result idx=%0d prob=%0d", $realtime,
                                 got.entry_index, got.probability);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    row = rows_q.pop_front();
                    if (got.entry_index !== row.entry_index
                        || got.probability !== row.probability
                        || got.alias_index !== row.alias_index
                        || got.zero_total !== row.zero_total
                        || got.last !== row.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("%0t: exp idx=%0d prob=%0d alias=%0d zero=%0d last=%0d",
                                     $realtime, row.entry_index, row.probability,
                                     row.alias_index, row.zero_total, row.last);
                            $display("%0t: got idx=%0d prob=%0d alias=%0d zero=%0d last=%0d",
                                     $realtime, got.entry_index, got.probability,
                                     got.alias_index, got.zero_total, got.last);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            rows_pending <= rows_q.size();
        end
    end

endmodule

// ===== tb/tb_alias_table_builder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alias_table_builder
// Drives weight sets of many sizes and totals (exact, zero, too small, huge)
// into the alias table builder with random idling on both sides, and
// reports the verdict from the table checker.
// ----------------------------------------------------------------------------
module tb_alias_table_builder;

    logic clk;
    logic rst_n;
    logic idle_en;
    int   mismatches;
    int   rows_pending;

    abt_item_if   item_ch ();
    abt_cfg_if    cfg_ch ();
    abt_result_if res_ch ();

    alias_table_builder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .cfg     (cfg_ch),
        .results (res_ch)
    );

    abt_table_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .items        (item_ch),
        .cfg          (cfg_ch),
        .results      (res_ch),
        .mismatches   (mismatches),
        .rows_pending (rows_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Stall the result side at random
    always @(posedge clk)
    begin
        res_ch.ready <= idle_en ? ($urandom_range(0, 99) >= 17) : 1'b1;
    end

    // Send one weight request, idling first at random
    task automatic send_weight(logic [31:0] w, logic [39:0] t);
        while (idle_en && $urandom_range(0, 99) < 17)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.weight <= w;
        item_ch.total <= t;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // Write entry_count once the table has drained
    task automatic write_count(logic [6:0] c);
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.entry_count <= c;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    // Send a whole set; the total is exact, zero, too small or random
    task automatic send_set(int cnt);
        logic [31:0] w;
        logic [39:0] sum;
        logic [39:0] t;
        int          mode;
        sum = '0;
        mode = $urandom_range(0, 19);
        for (int i = 0; i < cnt; i++)
        begin
            w = pick_weight();
            sum += w;
            if (i + 1 < cnt)
                send_weight(w, 40'({$urandom, $urandom}));
        end
        if (mode < 12)
            t = sum;
        else if (mode < 15)
            t = '0;
        else if (mode < 17)
            t = 40'({$urandom, $urandom});
        else
            t = 40'($urandom_range(1, 50));
        send_weight(w, t);
    endtask

    initial
    begin
        int sizes [8] = '{1, 2, 3, 4, 5, 6, 8, 12};
        int c;
        rst_n = 1'b0;
        idle_en = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.weight = '0;
        item_ch.total = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.entry_count = '0;
        res_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: two entries, extremes, zero total, saturation
        write_count(7'd2);
        send_weight('1, '0);
        send_weight('0, 40'hFF_FFFF_FFFF);
        send_weight(32'd5, '0);
        send_weight(32'd5, '0);
        send_weight(32'd1, '0);
        send_weight(32'd3, 40'd4);
        send_weight('1, '0);
        send_weight('1, 40'd1);
        send_weight(32'd7, '0);
        send_weight(32'd9, 40'd16);
        // Zero count acts as one entry
        write_count(7'd0);
        send_weight(32'd7, 40'd7);
        send_weight('1, 40'd1);
        send_weight(32'd0, '0);
        // Partial set dropped by a config write
        write_count(7'd3);
        send_weight(32'd11, '0);
        write_count(7'd3);
        send_weight(32'd1, '0);
        send_weight(32'd2, '0);
        send_weight(32'd3, 40'd6);

        // Random sets, no idling at first; one oversized count clamps to 64
        for (int s = 0; s < 7; s++)
        begin
            idle_en = (s >= 2);
            c = sizes[$urandom_range(0, 7)];
            if (s == 4)
                c = 127;
            write_count(7'(c));
            repeat ((c > 64) ? 1 : $urandom_range(1, 2))
                send_set((c > 64) ? 64 : c);
        end
        item_ch.valid <= 1'b0;

        // Drain the last table
        @(posedge clk);
        while (rows_pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("alias_table_builder verification clean");
        else
            $display("alias_table_builder verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("alias_table_builder verification failed");
        $finish;
    end

endmodule
